>>> sv/rsmw_pkg.sv
// ============================================================================
// Residue sieve package
// Register indexes, field widths and the layout of a residue class register.
// ============================================================================
package rsmw_pkg;

   localparam int unsigned MOD_W    = 16;
   localparam int unsigned OFF_W    = 16;
   localparam int unsigned WGT_W    = 16;
   localparam int unsigned WEIGHT_W = 18;
   localparam int unsigned RANGE_W  = 16;
   localparam int unsigned CSR_W    = 48;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

   localparam int unsigned REG_RANGE_MIN  = 0;
   localparam int unsigned REG_RANGE_MAX  = 1;
   localparam int unsigned REG_CLASS_BASE = 2;

   typedef struct packed {
      logic [WGT_W-1:0] weight;
      logic [OFF_W-1:0] offset;
      logic [MOD_W-1:0] modulus;
   } class_fields_type;

endpackage

>>> sv/rsmw_if.sv
// ============================================================================
// Residue sieve channels
// Valid/ready channels for candidate requests and membership responses.
// ============================================================================
interface rsmw_req_if #(parameter int VALUE_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink (input valid, input candidate, output ready);
endinterface

interface rsmw_rsp_if #(parameter int VALUE_WIDTH = 16);
   logic                                valid;
   logic                                ready;
   logic signed [VALUE_WIDTH-1:0]       echo_value;
   logic                                member;
   logic [rsmw_pkg::WEIGHT_W-1:0]       weight;

   modport source (output valid, output echo_value, output member, output weight,
                   input ready);
   modport sink (input valid, input echo_value, input member, input weight,
                 output ready);
endinterface

>>> sv/residue_sieve_member_weight.sv
// ============================================================================
// Residue sieve member and weight
// Tests each candidate against a union of residue classes and sums the
// weights of the classes to which it is congruent.
// ============================================================================
//
//   Channel   Direction  Content
//   req_ch    in         candidate
//   rsp_ch    out        echo_value, member, weight
//   csr_*     in         csr_we, csr_index, csr_wdata
//
// One transaction enters per cycle while no response stall holds the pipeline.
// It passes through the restoring remainder pipeline, which takes one dividend
// bit per stage for all classes in parallel, then the congruence and output stages.
// Reset is synchronous and clears the configuration registers and all stage valid bits.
// A stalled response holds its stage; earlier stages keep moving into empty
// stages, so bubbles are squeezed out and nothing is dropped or repeated.
module residue_sieve_member_weight #(
   parameter int NUM_CLASSES = 4,
   parameter int VALUE_WIDTH = 16,
   localparam int IDX_W = $clog2(NUM_CLASSES + 2)
) (
   input  logic                       clock,
   input  logic                       reset,
   rsmw_req_if.sink                   req_ch,
   rsmw_rsp_if.source                 rsp_ch,
   input  logic                       csr_we,
   input  logic [IDX_W-1:0]           csr_index,
   input  logic [rsmw_pkg::CSR_W-1:0] csr_wdata
);

   localparam int VW     = VALUE_WIDTH;
   localparam int NC     = NUM_CLASSES;
   localparam int AW     = (VW > 16) ? VW : 16;
   localparam int DIFF_W = AW + 1;
   localparam int CMP_W  = (VW > 18) ? VW : 18;
   localparam int MW     = rsmw_pkg::MOD_W;
   localparam int WW     = rsmw_pkg::WGT_W;
   localparam int OW     = rsmw_pkg::WEIGHT_W;
   localparam int SUM_R  = WW + $clog2(NC + 1);
   localparam int SUM_W  = (SUM_R > OW) ? SUM_R : OW;
   localparam int FIN    = AW + 1;
   localparam int LAST   = AW + 2;
   localparam int DEPTH  = AW + 3;

   typedef struct packed {
      logic [MW-1:0] rem;
      logic [AW-1:0] dvd;
   } lane_type;

   typedef struct packed {
      logic [VW-1:0]           value;
      logic [NC-1:0]           hit;
      lane_type [NC-1:0]       lane;
   } div_stage_type;

   typedef struct packed {
      logic [VW-1:0]           value;
      logic                    member;
      logic [NC-1:0][WW-1:0]   wgt;
   } fin_stage_type;

   logic [rsmw_pkg::RANGE_W-1:0] range_min_ff;
   logic [rsmw_pkg::RANGE_W-1:0] range_max_ff;
   logic [rsmw_pkg::CSR_W-1:0]   class_ff [NC];
   rsmw_pkg::class_fields_type   cls [NC];

   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   logic [DEPTH-1:0] en;

   div_stage_type entry_in;
   div_stage_type div_ff [AW+1];
   div_stage_type div_in [AW+1];
   fin_stage_type fin_ff;
   fin_stage_type fin_in;

   logic signed [VW-1:0] out_value_ff;
   logic signed [VW-1:0] out_value_in;
   logic                 out_member_ff;
   logic                 out_member_in;
   logic [OW-1:0]        out_weight_ff;
   logic [OW-1:0]        out_weight_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= '0;
         range_max_ff <= '0;
         for (int c = 0; c < NC; c++) begin
            class_ff[c] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            IDX_W'(rsmw_pkg::REG_RANGE_MIN): begin
               range_min_ff <= csr_wdata[rsmw_pkg::RANGE_W-1:0];
            end
            IDX_W'(rsmw_pkg::REG_RANGE_MAX): begin
               range_max_ff <= csr_wdata[rsmw_pkg::RANGE_W-1:0];
            end
            default: begin
               for (int c = 0; c < NC; c++) begin
                  if (csr_index == IDX_W'(rsmw_pkg::REG_CLASS_BASE + c)) begin
                     class_ff[c] <= csr_wdata;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         cls[c] = rsmw_pkg::class_fields_type'(class_ff[c]);
      end
   end

   // Stage handshake: a stage loads when it is empty or its content moves on.
   always_comb begin
      en[DEPTH-1] = !vld_ff[DEPTH-1] || rsp_ch.ready;
      for (int k = DEPTH - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in[0] = en[0] ? req_ch.valid : vld_ff[0];
      for (int k = 1; k < DEPTH; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Entry stage: range and threshold tests, absolute difference to offset.
   always_comb begin
      logic signed [CMP_W-1:0]  v_cmp;
      logic signed [CMP_W-1:0]  off_cmp;
      logic signed [CMP_W-1:0]  mod_cmp;
      logic signed [DIFF_W-1:0] diff;
      logic signed [DIFF_W-1:0] lo_ext;
      logic signed [DIFF_W-1:0] hi_ext;
      logic signed [DIFF_W-1:0] v_ext;
      logic                     in_range;
      logic                     min_zero;

      v_ext    = DIFF_W'(req_ch.candidate);
      lo_ext   = DIFF_W'(signed'(range_min_ff));
      hi_ext   = DIFF_W'(signed'(range_max_ff));
      in_range = (v_ext >= lo_ext) && (v_ext <= hi_ext);
      min_zero = (range_min_ff == '0);
      v_cmp    = CMP_W'(req_ch.candidate);

      entry_in.value = req_ch.candidate;
      for (int c = 0; c < NC; c++) begin
         off_cmp = CMP_W'(signed'(cls[c].offset));
         mod_cmp = CMP_W'(signed'({1'b0, cls[c].modulus}));
         diff    = v_ext - DIFF_W'(signed'(cls[c].offset));
         entry_in.hit[c] = in_range && (cls[c].modulus != '0) &&
                           ((v_cmp >= off_cmp + mod_cmp) ||
                            (min_zero && (v_cmp == off_cmp)));
         entry_in.lane[c].rem = '0;
         entry_in.lane[c].dvd = diff[DIFF_W-1] ? AW'(-diff) : AW'(diff);
      end
   end

   // Restoring remainder: one dividend bit per stage for every class.
   always_comb begin
      logic [MW:0] part;
      div_in[0] = entry_in;
      for (int k = 1; k <= AW; k++) begin
         div_in[k].value = div_ff[k-1].value;
         div_in[k].hit   = div_ff[k-1].hit;
         for (int c = 0; c < NC; c++) begin
            part = {div_ff[k-1].lane[c].rem, div_ff[k-1].lane[c].dvd[AW-1]};
            if (part >= {1'b0, cls[c].modulus}) begin
               part = part - {1'b0, cls[c].modulus};
            end
            div_in[k].lane[c].rem = part[MW-1:0];
            div_in[k].lane[c].dvd = {div_ff[k-1].lane[c].dvd[AW-2:0], 1'b0};
         end
      end
   end

   // Congruence resolution: gate weights and collect membership.
   always_comb begin
      logic [NC-1:0] cong;
      for (int c = 0; c < NC; c++) begin
         cong[c] = (cls[c].modulus != '0) && (div_ff[AW].lane[c].rem == '0);
         fin_in.wgt[c] = cong[c] ? cls[c].weight : '0;
      end
      fin_in.value  = div_ff[AW].value;
      fin_in.member = |(cong & div_ff[AW].hit);
   end

   // Output stage: saturating weight sum.
   always_comb begin
      logic [SUM_W-1:0] sum;
      sum = '0;
      for (int c = 0; c < NC; c++) begin
         sum = sum + SUM_W'(fin_ff.wgt[c]);
      end
      out_weight_in = (sum > SUM_W'(rsmw_pkg::WEIGHT_MAX)) ? rsmw_pkg::WEIGHT_MAX :
                                                           sum[OW-1:0];
      out_value_in  = signed'(fin_ff.value);
      out_member_in = fin_ff.member;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= AW; k++) begin
         if (en[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
      if (en[FIN]) begin
         fin_ff <= fin_in;
      end
      if (en[LAST]) begin
         out_value_ff  <= out_value_in;
         out_member_ff <= out_member_in;
         out_weight_ff <= out_weight_in;
      end
   end

   assign req_ch.ready      = en[0];
   assign rsp_ch.valid      = vld_ff[DEPTH-1];
   assign rsp_ch.echo_value = out_value_ff;
   assign rsp_ch.member     = out_member_ff;
   assign rsp_ch.weight     = out_weight_ff;

endmodule

>>> sv/rsmw_checker.sv
// ============================================================================
// Residue sieve port checker
// Watches the ports of the sieve for ordering, occupancy and stall behavior.
// ============================================================================
module rsmw_checker #(
   parameter int VALUE_WIDTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [VALUE_WIDTH-1:0]        rsp_echo_value,
   input logic                          rsp_member,
   input logic [rsmw_pkg::WEIGHT_W-1:0] rsp_weight
);

   localparam int AW    = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16;
   localparam int DEPTH = AW + 3;
   localparam int CNT_W = $clog2(DEPTH + 2);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             req_acc;
   logic             rsp_acc;

   assign req_acc  = req_valid && req_ready;
   assign rsp_acc  = rsp_valid && rsp_ready;
   assign count_in = count_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A stalled response keeps its content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable({rsp_echo_value, rsp_member, rsp_weight}))
      else $error("response changed while stalled");

   // Every response answers an earlier transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> count_ff != '0)
      else $error("response without a pending transaction");

   // No more transactions in flight than the pipeline holds.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("too many transactions in flight");

   // An empty output stage never blocks the input.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with no response pending");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind residue_sieve_member_weight rsmw_checker #(
   .VALUE_WIDTH(VALUE_WIDTH)
) u_rsmw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_echo_value (rsp_ch.echo_value),
   .rsp_member     (rsp_ch.member),
   .rsp_weight     (rsp_ch.weight)
);
